@@ rtl/pdec_pkg.sv @@
// Shared types, constants and helpers of the planar tile graphics decoder.
`timescale 1ns / 1ps
`default_nettype none
package pdec_pkg;

   localparam int ROM_ADDR_WIDTH_DEFAULT = 13;
   localparam int MAX_TILE_DIM_DEFAULT   = 16;
   localparam int QUEUE_DEPTH            = 4;

   localparam logic [1:0] OP_LOAD_COLUMN = 2'd0;
   localparam logic [1:0] OP_LOAD_ROW    = 2'd1;
   localparam logic [1:0] OP_LOAD_ROM    = 2'd2;
   localparam logic [1:0] OP_DECODE      = 2'd3;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] REG_PLANE_COUNT     = 3'd0;
   localparam logic [2:0] REG_TILE_WIDTH      = 3'd1;
   localparam logic [2:0] REG_TILE_HEIGHT     = 3'd2;
   localparam logic [2:0] REG_TILE_INCREMENT  = 3'd3;
   localparam logic [2:0] REG_PLANE_INCREMENT = 3'd4;

   localparam logic [3:0]  PLANE_COUNT_RESET     = 4'd2;
   localparam logic [4:0]  TILE_WIDTH_RESET      = 5'd8;
   localparam logic [4:0]  TILE_HEIGHT_RESET     = 5'd8;
   localparam logic [15:0] TILE_INCREMENT_RESET  = 16'd128;
   localparam logic [15:0] PLANE_INCREMENT_RESET = 16'd4;

   localparam logic [7:0] BIT_SELECT = 8'h80;

   typedef struct packed {
      logic [3:0]  plane_count;
      logic [4:0]  tile_width;
      logic [4:0]  tile_height;
      logic [15:0] tile_increment;
      logic [15:0] plane_increment;
   } cfg_type;

   // value carries the bit offset for table loads, the row base bit address for decodes
   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  table_index;
      logic [15:0] value;
      logic [12:0] rom_address;
      logic [7:0]  rom_byte;
   } cmd_type;

   function automatic logic [4:0] clamp_dim(input logic [4:0] v, input logic [4:0] lim);
      return (v > lim) ? lim : v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/planar_tile_graphics_decoder.sv @@
// Top level of the planar tile graphics decoder: config registers and front/queue/back.
// Column offset and ROM byte loads are written in the back end, row offset loads
// in the front end. A decode beat emits one pixel per column of the row; each pixel
// fetches one bit per plane (one fetch when plane_count is zero) on the single
// graphics ROM read port. A four-entry command queue lets the front end keep taking
// beats, and row offset loads, while the back end is busy, until the queue fills;
// the back end stalls on rsp_stall and while a pixel's last fetch is still on its way
// to the output register. Config writes are taken at any time and are meant to be
// made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module planar_tile_graphics_decoder #(
   parameter int ROM_ADDR_WIDTH = pdec_pkg::ROM_ADDR_WIDTH_DEFAULT,
   parameter int MAX_TILE_DIM   = pdec_pkg::MAX_TILE_DIM_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_table_index,
   input  wire logic [15:0] req_bit_offset,
   input  wire logic [12:0] req_rom_address,
   input  wire logic [7:0]  req_rom_byte,
   input  wire logic [9:0]  req_tile_number,
   input  wire logic [3:0]  req_row_number,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_pixel,
   output logic [3:0]       rsp_column,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [pdec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [15:0] csr_data
);

   pdec_pkg::cfg_type cfg_ff;
   pdec_pkg::cmd_type push_cmd;
   pdec_pkg::cmd_type pop_cmd;
   logic push_valid;
   logic push_ready;
   logic pop_valid;
   logic pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_count     <= pdec_pkg::PLANE_COUNT_RESET;
         cfg_ff.tile_width      <= pdec_pkg::TILE_WIDTH_RESET;
         cfg_ff.tile_height     <= pdec_pkg::TILE_HEIGHT_RESET;
         cfg_ff.tile_increment  <= pdec_pkg::TILE_INCREMENT_RESET;
         cfg_ff.plane_increment <= pdec_pkg::PLANE_INCREMENT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pdec_pkg::REG_PLANE_COUNT:     cfg_ff.plane_count     <= csr_data[3:0];
            pdec_pkg::REG_TILE_WIDTH:      cfg_ff.tile_width      <= csr_data[4:0];
            pdec_pkg::REG_TILE_HEIGHT:     cfg_ff.tile_height     <= csr_data[4:0];
            pdec_pkg::REG_TILE_INCREMENT:  cfg_ff.tile_increment  <= csr_data;
            pdec_pkg::REG_PLANE_INCREMENT: cfg_ff.plane_increment <= csr_data;
            default: ;
         endcase
      end
   end

   pdec_front #(
      .MAX_TILE_DIM(MAX_TILE_DIM)
   ) u_front (
      .clock           (clock),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_table_index (req_table_index),
      .req_bit_offset  (req_bit_offset),
      .req_rom_address (req_rom_address),
      .req_rom_byte    (req_rom_byte),
      .req_tile_number (req_tile_number),
      .req_row_number  (req_row_number),
      .push_ready      (push_ready),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd)
   );

   pdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pdec_back #(
      .ROM_ADDR_WIDTH (ROM_ADDR_WIDTH),
      .MAX_TILE_DIM   (MAX_TILE_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_pixel  (rsp_pixel),
      .rsp_column (rsp_column),
      .rsp_last   (rsp_last)
   );

endmodule
`default_nettype wire

@@ rtl/pdec_front.sv @@
// Front end: accepts items, owns the row offset table, forms decode base addresses.
`timescale 1ns / 1ps
`default_nettype none
module pdec_front #(
   parameter int MAX_TILE_DIM = pdec_pkg::MAX_TILE_DIM_DEFAULT
) (
   input  wire logic               clock,
   input  wire pdec_pkg::cfg_type  cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [3:0]         req_table_index,
   input  wire logic [15:0]        req_bit_offset,
   input  wire logic [12:0]        req_rom_address,
   input  wire logic [7:0]         req_rom_byte,
   input  wire logic [9:0]         req_tile_number,
   input  wire logic [3:0]         req_row_number,
   input  wire logic               push_ready,
   output logic                    push_valid,
   output pdec_pkg::cmd_type       push_cmd
);

   localparam int IW = $clog2(MAX_TILE_DIM);
   localparam logic [4:0] DimMax = 5'(MAX_TILE_DIM);

   logic [15:0] row_table_ff [MAX_TILE_DIM];

   logic        accept;
   logic        index_ok;
   logic        row_ok;
   logic [4:0]  width_eff;
   logic [4:0]  height_eff;
   logic [15:0] product;
   logic [15:0] base;

   assign req_stall  = !push_ready;
   assign accept     = req_valid && push_ready;
   assign index_ok   = {1'b0, req_table_index} < DimMax;
   assign width_eff  = pdec_pkg::clamp_dim(cfg.tile_width, DimMax);
   assign height_eff = pdec_pkg::clamp_dim(cfg.tile_height, DimMax);
   assign row_ok     = {1'b0, req_row_number} < height_eff;
   // bit addresses wrap at 16 bits, so only the low product bits matter
   assign product    = 16'(req_tile_number) * cfg.tile_increment;
   assign base       = product + row_table_ff[req_row_number[IW-1:0]];

   always_comb begin
      push_valid = 1'b0;
      case (req_op)
         pdec_pkg::OP_LOAD_COLUMN: push_valid = accept && index_ok;
         pdec_pkg::OP_LOAD_ROW:    push_valid = 1'b0;
         pdec_pkg::OP_LOAD_ROM:    push_valid = accept;
         pdec_pkg::OP_DECODE:      push_valid = accept && (width_eff != 5'd0) && row_ok;
         default:                  push_valid = 1'b0;
      endcase
   end

   always_comb begin
      push_cmd.op          = req_op;
      push_cmd.table_index = req_table_index;
      push_cmd.value       = (req_op == pdec_pkg::OP_DECODE) ? base : req_bit_offset;
      push_cmd.rom_address = req_rom_address;
      push_cmd.rom_byte    = req_rom_byte;
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == pdec_pkg::OP_LOAD_ROW) && index_ok) begin
         row_table_ff[req_table_index[IW-1:0]] <= req_bit_offset;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pdec_queue.sv @@
// Short command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module pdec_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire pdec_pkg::cmd_type push_cmd,
   output logic                   push_ready,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output pdec_pkg::cmd_type      pop_cmd
);

   localparam int PW = $clog2(pdec_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(pdec_pkg::QUEUE_DEPTH + 1);

   pdec_pkg::cmd_type entry_ff [pdec_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign push_ready = count_ff != CW'(pdec_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pdec_back.sv @@
// Back end: column table, graphics ROM, bit fetch sequencer and pixel output register.
`timescale 1ns / 1ps
`default_nettype none
module pdec_back #(
   parameter int ROM_ADDR_WIDTH = pdec_pkg::ROM_ADDR_WIDTH_DEFAULT,
   parameter int MAX_TILE_DIM   = pdec_pkg::MAX_TILE_DIM_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pdec_pkg::cfg_type cfg,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire pdec_pkg::cmd_type pop_cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_pixel,
   output logic [3:0]             rsp_column,
   output logic                   rsp_last
);

   localparam int AW = ROM_ADDR_WIDTH;
   localparam int BW = ROM_ADDR_WIDTH + 3;
   localparam int IW = $clog2(MAX_TILE_DIM);
   localparam logic [4:0] DimMax = 5'(MAX_TILE_DIM);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic [15:0] col_table_ff [MAX_TILE_DIM];
   logic [7:0]  rom_ff [2**AW];

   logic          state_ff, state_in;
   logic [BW-1:0] base_ff, base_in;
   logic [3:0]    col_ff, col_in;
   logic [3:0]    plane_ff, plane_in;
   logic [BW-1:0] plane_off_ff, plane_off_in;

   logic [7:0] rom_q_ff;
   logic       rd_valid_ff, rd_valid_in;
   logic [2:0] rd_sel_ff;
   logic       rd_first_ff;
   logic       rd_last_plane_ff;
   logic [3:0] rd_col_ff;
   logic       rd_last_col_ff;

   logic [7:0] pix_ff, pix_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_pixel_ff;
   logic [3:0] out_column_ff;
   logic       out_last_ff;

   logic          pop;
   logic [4:0]    width_eff;
   logic [3:0]    nplanes;
   logic          zero_planes;
   logic          last_plane;
   logic          last_col;
   logic          pending;
   logic          out_free;
   logic          issue;
   logic [BW-1:0] addr;
   logic [7:0]    shifted;
   logic          bit_val;
   logic [7:0]    prev;
   logic          load_out;

   assign pop         = pop_valid && pop_ready;
   assign pop_ready   = state_ff == ST_IDLE;
   assign width_eff   = pdec_pkg::clamp_dim(cfg.tile_width, DimMax);
   assign zero_planes = cfg.plane_count == 4'd0;
   assign nplanes     = zero_planes ? 4'd1 : cfg.plane_count;
   assign last_plane  = plane_ff == (nplanes - 4'd1);
   assign last_col    = ({1'b0, col_ff} + 5'd1) == width_eff;
   // the last fetch of a column sits in the ROM read register, on its way to the output register
   assign pending     = rd_valid_ff && rd_last_plane_ff;
   assign out_free    = (!out_valid_ff || !rsp_stall) && !pending;
   assign issue       = (state_ff == ST_RUN) && (!last_plane || out_free);
   assign addr        = base_ff + col_table_ff[col_ff[IW-1:0]][BW-1:0] + plane_off_ff;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      plane_in     = plane_ff;
      plane_off_in = plane_off_ff;
      rd_valid_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop && (pop_cmd.op == pdec_pkg::OP_DECODE)) begin
               state_in     = ST_RUN;
               base_in      = pop_cmd.value[BW-1:0];
               col_in       = 4'd0;
               plane_in     = 4'd0;
               plane_off_in = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               rd_valid_in = 1'b1;
               if (last_plane) begin
                  plane_in     = 4'd0;
                  plane_off_in = '0;
                  if (last_col) begin
                     state_in = ST_IDLE;
                  end else begin
                     col_in = col_ff + 4'd1;
                  end
               end else begin
                  plane_in     = plane_ff + 4'd1;
                  plane_off_in = plane_off_ff + cfg.plane_increment[BW-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      col_ff       <= col_in;
      plane_ff     <= plane_in;
      plane_off_ff <= plane_off_in;
      if (issue) begin
         rd_sel_ff        <= addr[2:0];
         rd_first_ff      <= plane_ff == 4'd0;
         rd_last_plane_ff <= last_plane;
         rd_col_ff        <= col_ff;
         rd_last_col_ff   <= last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (pop_cmd.op == pdec_pkg::OP_LOAD_COLUMN)) begin
         col_table_ff[pop_cmd.table_index[IW-1:0]] <= pop_cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (pop_cmd.op == pdec_pkg::OP_LOAD_ROM)) begin
         rom_ff[pop_cmd.rom_address[AW-1:0]] <= pop_cmd.rom_byte;
      end
      if (issue) begin
         rom_q_ff <= rom_ff[addr[BW-1:3]];
      end
   end

   assign shifted  = rom_q_ff << rd_sel_ff;
   assign bit_val  = |(shifted & pdec_pkg::BIT_SELECT);
   assign prev     = rd_first_ff ? 8'd0 : pix_ff;
   assign load_out = rd_valid_ff && rd_last_plane_ff;

   always_comb begin
      pix_in = pix_ff;
      if (rd_valid_ff) begin
         pix_in = zero_planes ? 8'd0 : {prev[6:0], bit_val};
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (load_out) begin
         out_pixel_ff  <= pix_in;
         out_column_ff <= rd_col_ff;
         out_last_ff   <= rd_last_col_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_pixel  = out_pixel_ff;
   assign rsp_column = out_column_ff;
   assign rsp_last   = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/pdec_checker.sv @@
// Port-level checker of the planar tile graphics decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pdec_checker #(
   parameter int MAX_TILE_DIM = pdec_pkg::MAX_TILE_DIM_DEFAULT
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_pixel,
   input wire logic [3:0]  rsp_column,
   input wire logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel)
         && $stable(rsp_column) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_last_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_column != 4'(MAX_TILE_DIM - 1))
      else $error("widest column not flagged last");

   a_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_req_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind planar_tile_graphics_decoder pdec_checker #(
   .MAX_TILE_DIM(MAX_TILE_DIM)
) u_pdec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_pixel  (rsp_pixel),
   .rsp_column (rsp_column),
   .rsp_last   (rsp_last)
);
`default_nettype wire
